### hw/rtl/xrd_pkg.sv
// shared types, constants and helpers for the ranged xorshift draw
`default_nettype none
package xrd_pkg;

  localparam int DATA_W      = 64;
  localparam int CNT_W       = $clog2(DATA_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [DATA_W-1:0] GEN_RESET = 64'h0000_DEAD_BEEF_0000;
  localparam int SHIFT_A = 3;
  localparam int SHIFT_B = 27;
  localparam int SHIFT_C = 11;

  localparam logic [1:0] CMD_DRAW = 2'd0;
  localparam logic [1:0] CMD_SEED = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  typedef struct packed {
    logic              divide;
    logic              zero;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] span;
    logic [DATA_W-1:0] addend;
    logic [DATA_W-1:0] state;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } bk_state_t;

  function automatic logic [DATA_W-1:0] xs_advance(input logic [DATA_W-1:0] s);
    logic [DATA_W-1:0] n;
    n = s;
    n = n ^ (n << SHIFT_A);
    n = n ^ (n >> SHIFT_B);
    n = n ^ (n << SHIFT_C);
    return n;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/xrd_in_if.sv
// input channel: command word with bounds and seed
`default_nettype none
interface xrd_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic signed [xrd_pkg::DATA_W-1:0] low_bound;
  logic signed [xrd_pkg::DATA_W-1:0] high_bound;
  logic [xrd_pkg::DATA_W-1:0]    seed_value;

  modport source(output valid, command, low_bound, high_bound, seed_value, input ready);
  modport sink(input valid, command, low_bound, high_bound, seed_value, output ready);
endinterface
`default_nettype wire

### hw/rtl/xrd_out_if.sv
// result channel: drawn value, state and zero span flag
`default_nettype none
interface xrd_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [xrd_pkg::DATA_W-1:0] drawn_value;
  logic [xrd_pkg::DATA_W-1:0]    state_value;
  logic                          zero_span;

  modport source(output valid, drawn_value, state_value, zero_span, input ready);
  modport sink(input valid, drawn_value, state_value, zero_span, output ready);
endinterface
`default_nettype wire

### hw/rtl/xorshift_ranged_integer_draw.sv
// top level of the ranged xorshift integer draw
//
// channel   dir  handshake     payload
// in_ch     in   valid/ready   command, low_bound, high_bound, seed_value
// out_ch    out  valid/ready   drawn_value, state_value, zero_span
//
// a draw with a non-zero span goes from queue to result register through pop,
// the 64 steps of the one-bit remainder unit and the offset add
// seed, read, spare and zero-span words skip the remainder steps in the back end
// the front takes a word whenever the two-entry queue has room
// reset is synchronous, active low, and loads the generator seed constant
`default_nettype none
module xorshift_ranged_integer_draw (
  input  wire logic clk,
  input  wire logic rst_n,
  xrd_in_if.sink    in_ch,
  xrd_out_if.source out_ch
);

  xrd_pkg::job_t push_data;
  xrd_pkg::job_t pop_data;
  logic          push;
  logic          full;
  logic          pop;
  logic          not_empty;

  xrd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .push_data (push_data),
    .push      (push),
    .full      (full)
  );

  xrd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty)
  );

  xrd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .not_empty (not_empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

### hw/rtl/xrd_front.sv
// front end: accepts words, steps the generator and builds jobs
`default_nettype none
module xrd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  xrd_in_if.sink             in_ch,
  output xrd_pkg::job_t      push_data,
  output logic               push,
  input  wire logic          full
);

  logic [xrd_pkg::DATA_W-1:0] gen_r;
  logic [xrd_pkg::DATA_W-1:0] gen_nxt;
  logic [xrd_pkg::DATA_W-1:0] raw;
  logic [xrd_pkg::DATA_W-1:0] span;
  logic                       accept;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;
  assign push        = accept;

  assign raw  = xrd_pkg::xs_advance(gen_r);
  assign span = in_ch.high_bound - in_ch.low_bound + xrd_pkg::DATA_W'(1);

  always_comb begin
    gen_nxt   = gen_r;
    push_data = '0;
    push_data.state = gen_r;
    unique case (in_ch.command)
      xrd_pkg::CMD_DRAW: begin
        gen_nxt            = raw;
        push_data.state    = raw;
        push_data.zero     = (span == '0);
        push_data.divide   = (span != '0);
        push_data.dividend = raw;
        push_data.span     = span;
        push_data.addend   = (span != '0) ? in_ch.low_bound : '0;
      end
      xrd_pkg::CMD_SEED: begin
        gen_nxt         = in_ch.seed_value;
        push_data.state = in_ch.seed_value;
      end
      xrd_pkg::CMD_READ: begin
        push_data.state = gen_r;
      end
      default: begin
        push_data.state = gen_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= xrd_pkg::GEN_RESET;
    end else if (accept) begin
      gen_r <= gen_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/xrd_queue.sv
// short job queue between front and back
`default_nettype none
module xrd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire xrd_pkg::job_t  push_data,
  output logic                full,
  input  wire logic           pop,
  output xrd_pkg::job_t       pop_data,
  output logic                not_empty
);

  xrd_pkg::job_t mem_r [xrd_pkg::QUEUE_DEPTH];
  logic [xrd_pkg::PTR_W-1:0] wr_ptr_r;
  logic [xrd_pkg::PTR_W-1:0] rd_ptr_r;
  logic [xrd_pkg::PTR_W:0]   count_r;
  logic [xrd_pkg::PTR_W:0]   count_nxt;

  assign full      = (count_r == (xrd_pkg::PTR_W+1)'(xrd_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    priority if (push && !pop) begin
      count_nxt = count_r + (xrd_pkg::PTR_W+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (xrd_pkg::PTR_W+1)'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + xrd_pkg::PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + xrd_pkg::PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/xrd_back.sv
// back end: serial remainder, offset add and result register
`default_nettype none
module xrd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           not_empty,
  input  wire xrd_pkg::job_t  pop_data,
  output logic                pop,
  xrd_out_if.source           out_ch
);

  xrd_pkg::bk_state_t state_r;
  xrd_pkg::bk_state_t state_nxt;

  logic [xrd_pkg::CNT_W-1:0]  cnt_r;
  logic [xrd_pkg::DATA_W-1:0] rem_r;
  logic [xrd_pkg::DATA_W-1:0] dvd_r;
  logic [xrd_pkg::DATA_W-1:0] span_r;
  logic [xrd_pkg::DATA_W-1:0] addend_r;
  logic [xrd_pkg::DATA_W-1:0] st_r;
  logic                       zero_r;

  logic                       out_valid_r;
  logic [xrd_pkg::DATA_W-1:0] drawn_r;
  logic [xrd_pkg::DATA_W-1:0] state_val_r;
  logic                       zero_span_r;

  logic [xrd_pkg::DATA_W:0]   rem_sh;
  logic [xrd_pkg::DATA_W:0]   diff;
  logic [xrd_pkg::DATA_W-1:0] rem_step;
  logic                       slot_free;
  logic                       load_out;
  logic                       last_step;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign last_step = (cnt_r == xrd_pkg::CNT_W'(xrd_pkg::DATA_W - 1));

  // one restoring remainder step
  assign rem_sh   = {rem_r, dvd_r[xrd_pkg::DATA_W-1]};
  assign diff     = rem_sh - {1'b0, span_r};
  assign rem_step = diff[xrd_pkg::DATA_W] ? rem_sh[xrd_pkg::DATA_W-1:0]
                                          : diff[xrd_pkg::DATA_W-1:0];

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      xrd_pkg::BK_IDLE: begin
        if (not_empty) begin
          pop       = 1'b1;
          state_nxt = pop_data.divide ? xrd_pkg::BK_DIV : xrd_pkg::BK_HOLD;
        end
      end
      xrd_pkg::BK_DIV: begin
        if (last_step) begin
          state_nxt = xrd_pkg::BK_HOLD;
        end
      end
      xrd_pkg::BK_HOLD: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = xrd_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = xrd_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= xrd_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cnt_r    <= '0;
      rem_r    <= '0;
      dvd_r    <= pop_data.dividend;
      span_r   <= pop_data.span;
      addend_r <= pop_data.addend;
      st_r     <= pop_data.state;
      zero_r   <= pop_data.zero;
    end else if (state_r == xrd_pkg::BK_DIV) begin
      cnt_r <= cnt_r + xrd_pkg::CNT_W'(1);
      rem_r <= rem_step;
      dvd_r <= {dvd_r[xrd_pkg::DATA_W-2:0], 1'b0};
    end
    if (load_out) begin
      drawn_r     <= rem_r + addend_r;
      state_val_r <= st_r;
      zero_span_r <= zero_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.drawn_value = drawn_r;
  assign out_ch.state_value = state_val_r;
  assign out_ch.zero_span   = zero_span_r;

endmodule
`default_nettype wire

### hw/rtl/xrd_checker.sv
// port checker for the ranged xorshift draw and its bind
`default_nettype none
module xrd_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [xrd_pkg::DATA_W-1:0]   drawn_value,
  input wire logic [xrd_pkg::DATA_W-1:0]   state_value,
  input wire logic                         zero_span
);

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a stalled word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(drawn_value) && $stable(state_value)
                                && $stable(zero_span))
    else $error("result payload changed while stalled");

  // full range gives a zero draw
  a_zero_draw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_span |-> drawn_value == '0)
    else $error("zero span with non-zero draw");

  // nothing offered straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind xorshift_ranged_integer_draw xrd_checker u_xrd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .drawn_value (out_ch.drawn_value),
  .state_value (out_ch.state_value),
  .zero_span   (out_ch.zero_span)
);
`default_nettype wire

### test/testbench.sv
// self-checking testbench for the ranged xorshift integer draw with random flow control
module testbench;

  localparam logic [1:0]                 CMD_SPARE = 2'd3;
  localparam logic [xrd_pkg::DATA_W-1:0] S64_MIN   = 64'h8000_0000_0000_0000;
  localparam logic [xrd_pkg::DATA_W-1:0] S64_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [xrd_pkg::DATA_W-1:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int RANDOM_WORDS = 1250;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [1:0]                 command;
    logic [xrd_pkg::DATA_W-1:0] low_bound;
    logic [xrd_pkg::DATA_W-1:0] high_bound;
    logic [xrd_pkg::DATA_W-1:0] seed_value;
  } draw_req_t;

  typedef struct {
    logic [xrd_pkg::DATA_W-1:0] drawn_value;
    logic [xrd_pkg::DATA_W-1:0] state_value;
    logic                       zero_span;
  } draw_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  xrd_in_if  in_ch();
  xrd_out_if out_ch();

  xorshift_ranged_integer_draw dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  draw_req_t                  words_to_send[$];
  draw_rsp_t                  results_due[$];
  logic [xrd_pkg::DATA_W-1:0] model_gen;
  int                         errors;
  int                         sent_count;
  int                         got_count;
  int                         per_command[4];
  int                         zero_spans;
  int                         in_gap;
  int                         out_stall;
  int                         stall_pick;

  function automatic logic [xrd_pkg::DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(40, 120);
  endfunction

  function automatic draw_rsp_t predict_word(input draw_req_t w);
    draw_rsp_t                  r;
    logic [xrd_pkg::DATA_W-1:0] n;
    logic [xrd_pkg::DATA_W-1:0] span;
    r.drawn_value = '0;
    r.zero_span   = 1'b0;
    case (w.command)
      xrd_pkg::CMD_DRAW: begin
        n = model_gen;
        n = n ^ (n << xrd_pkg::SHIFT_A);
        n = n ^ (n >> xrd_pkg::SHIFT_B);
        n = n ^ (n << xrd_pkg::SHIFT_C);
        model_gen = n;
        span = w.high_bound - w.low_bound + 64'd1;
        if (span == '0) begin
          r.zero_span = 1'b1;
          zero_spans++;
        end else begin
          r.drawn_value = (n % span) + w.low_bound;
        end
      end
      xrd_pkg::CMD_SEED: model_gen = w.seed_value;
      default: ;
    endcase
    r.state_value = model_gen;
    return r;
  endfunction

  task automatic add_word(input logic [1:0] cmd, input logic [xrd_pkg::DATA_W-1:0] lo,
                          input logic [xrd_pkg::DATA_W-1:0] hi,
                          input logic [xrd_pkg::DATA_W-1:0] seed);
    draw_req_t w;
    w.command    = cmd;
    w.low_bound  = lo;
    w.high_bound = hi;
    w.seed_value = seed;
    words_to_send.push_back(w);
  endtask

  task automatic add_random_word();
    logic [1:0]                 cmd;
    logic [xrd_pkg::DATA_W-1:0] lo;
    logic [xrd_pkg::DATA_W-1:0] hi;
    logic [xrd_pkg::DATA_W-1:0] seed;
    int                         r;
    r = $urandom_range(0, 99);
    if (r < 72) cmd = xrd_pkg::CMD_DRAW;
    else if (r < 82) cmd = xrd_pkg::CMD_SEED;
    else if (r < 93) cmd = xrd_pkg::CMD_READ;
    else cmd = CMD_SPARE;
    lo = rand64();
    hi = rand64();
    case ($urandom_range(0, 5))
      0: hi = lo + $urandom_range(0, 1000);
      1: ;
      2: begin
        lo = {{32{hi[31]}}, hi[31:0]};
        hi = lo + {32'd0, $urandom};
      end
      3: hi = lo - 64'd1;
      4: begin
        lo = S64_MAX - $urandom_range(0, 50);
        hi = lo + $urandom_range(0, 200);
      end
      default: hi = lo + (64'd1 << $urandom_range(0, 63)) - 64'd1;
    endcase
    r = $urandom_range(0, 39);
    if (r == 0) seed = '0;
    else if (r == 1) seed = ALL_ONES;
    else seed = rand64();
    add_word(cmd, lo, hi, seed);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        draw_req_t acc;
        acc.command    = in_ch.command;
        acc.low_bound  = in_ch.low_bound;
        acc.high_bound = in_ch.high_bound;
        acc.seed_value = in_ch.seed_value;
        per_command[acc.command]++;
        results_due.push_back(predict_word(acc));
        sent_count++;
      end
      if (in_gap > 0) begin
        in_ch.valid <= 1'b0;
        in_gap--;
      end else if (words_to_send.size() > 0) begin
        draw_req_t nxt;
        nxt = words_to_send.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.command    <= nxt.command;
        in_ch.low_bound  <= nxt.low_bound;
        in_ch.high_bound <= nxt.high_bound;
        in_ch.seed_value <= nxt.seed_value;
        // back-to-back stretches
        in_gap = (sent_count % 200 < 40) ? 0 : idle_length();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_count++;
        if (results_due.size() == 0) begin
          $error("unexpected result word: drawn_value %h state_value %h zero_span %b",
                 out_ch.drawn_value, out_ch.state_value, out_ch.zero_span);
          errors++;
        end else begin
          draw_rsp_t e;
          e = results_due.pop_front();
          if (out_ch.drawn_value !== e.drawn_value) begin
            $error("drawn_value: expected %h, got %h", e.drawn_value, out_ch.drawn_value);
            errors++;
          end
          if (out_ch.state_value !== e.state_value) begin
            $error("state_value: expected %h, got %h", e.state_value, out_ch.state_value);
            errors++;
          end
          if (out_ch.zero_span !== e.zero_span) begin
            $error("zero_span: expected %b, got %b", e.zero_span, out_ch.zero_span);
            errors++;
          end
        end
      end
      if (out_stall > 0) begin
        out_ch.ready <= 1'b0;
        out_stall--;
      end else if (got_count % 150 < 30 || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        stall_pick = idle_length();
        out_ch.ready <= (stall_pick == 0);
        out_stall = (stall_pick > 0) ? stall_pick - 1 : 0;
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.command    = xrd_pkg::CMD_READ;
    in_ch.low_bound  = '0;
    in_ch.high_bound = '0;
    in_ch.seed_value = '0;
    out_ch.ready     = 1'b0;
    model_gen        = xrd_pkg::GEN_RESET;
    errors           = 0;
    sent_count       = 0;
    got_count        = 0;
    zero_spans       = 0;
    per_command      = '{default: 0};

    // directed words
    add_word(xrd_pkg::CMD_READ, rand64(), rand64(), rand64());
    add_word(xrd_pkg::CMD_DRAW, S64_MIN,  S64_MAX,  rand64());
    add_word(xrd_pkg::CMD_DRAW, '0,       '0,       ALL_ONES);
    add_word(xrd_pkg::CMD_DRAW, S64_MAX,  S64_MAX,  '0);
    add_word(xrd_pkg::CMD_DRAW, S64_MIN,  S64_MIN,  '0);
    add_word(xrd_pkg::CMD_DRAW, 64'd100,  -64'sd100, '0);
    add_word(xrd_pkg::CMD_DRAW, 64'd5,    64'd4,    '0);
    add_word(xrd_pkg::CMD_DRAW, ALL_ONES, S64_MAX,  '0);
    add_word(xrd_pkg::CMD_DRAW, 64'd1,    ALL_ONES, '0);
    add_word(xrd_pkg::CMD_DRAW, S64_MAX - 64'd3, S64_MAX + 64'd5, '0);
    add_word(CMD_SPARE,         ALL_ONES, ALL_ONES, ALL_ONES);
    add_word(xrd_pkg::CMD_SEED, ALL_ONES, S64_MIN,  '0);
    add_word(xrd_pkg::CMD_DRAW, '0,       64'd9,    ALL_ONES);
    add_word(xrd_pkg::CMD_DRAW, S64_MIN,  S64_MAX,  '0);
    add_word(xrd_pkg::CMD_READ, '0,       '0,       '0);
    add_word(xrd_pkg::CMD_SEED, '0,       '0,       ALL_ONES);
    add_word(xrd_pkg::CMD_DRAW, S64_MIN,  ALL_ONES, '0);
    add_word(xrd_pkg::CMD_READ, S64_MAX,  S64_MIN,  '0);
    add_word(xrd_pkg::CMD_SEED, '0,       '0,       64'd1);
    add_word(xrd_pkg::CMD_DRAW, 64'd7,    64'd7,    '0);
    add_word(xrd_pkg::CMD_DRAW, -64'sd3,  64'd3,    '0);
    add_word(CMD_SPARE,         '0,       '0,       '0);
    add_word(xrd_pkg::CMD_SEED, '0,       '0,       S64_MIN);
    add_word(xrd_pkg::CMD_DRAW, '0,       S64_MAX,  '0);
    repeat (RANDOM_WORDS) add_random_word();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (words_to_send.size() > 0 || in_ch.valid) @(posedge clk);
    while (results_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d words: %0d draws (%0d zero span), %0d seeds, %0d reads, %0d spare",
             sent_count, per_command[xrd_pkg::CMD_DRAW], zero_spans,
             per_command[xrd_pkg::CMD_SEED], per_command[xrd_pkg::CMD_READ],
             per_command[CMD_SPARE]);
    $display("%0d result words checked, %0d mismatches", got_count, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
